### sv/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the timeout table scheduler
// Request op codes, the packed table row and the evaluation unit result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [31:0] ID_FIRST = 32'd1;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] dur;
    logic [31:0] tag;
    logic        started;
    logic [31:0] start;
    logic [31:0] expiry;
  } tts_row_t;

  localparam int unsigned ROW_W = $bits(tts_row_t);

  typedef struct packed {
    logic        expired;
    logic        id_match;
    logic [31:0] expiry;
  } tts_eval_t;

endpackage

`default_nettype wire

### sv/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/tts_eval.sv
// ----------------------------------------------------------------------------
// tts_eval: per-slot evaluation unit
// Expiry sum, wraparound-aware expiry test and id match for one table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tts_eval (
  input  wire tts_pkg::tts_row_t  row_i,
  input  wire logic [31:0]        now_i,
  input  wire logic [31:0]        eid_i,
  output tts_pkg::tts_eval_t      res_o
);

  import tts_pkg::*;

  logic past_exp;
  logic before_start;

  assign past_exp     = now_i >= row_i.expiry;
  assign before_start = now_i < row_i.start;

  always_comb begin
    res_o.expiry   = now_i + row_i.dur;
    res_o.id_match = row_i.id == eid_i;
    if (row_i.expiry >= row_i.start) begin
      res_o.expired = past_exp || before_start;
    end else begin
      res_o.expired = past_exp && before_start;
    end
  end

endmodule

`default_nettype wire

### sv/timeout_table_scheduler.sv
// ----------------------------------------------------------------------------
// timeout_table_scheduler: compacted table of pending timeouts
// Add, remove-by-id and tick requests over a RAM-held table of SLOTS rows.
// ----------------------------------------------------------------------------
// Usage: drive op_i and its fields and raise start_i; the request is taken
// at the edge where start_i is high and busy_o is low. Exactly one result
// follows per request, shown on ok_o, result_id_o and fired_tag_o for the
// single cycle in which done_o is high; the receiver cannot stall it.
// Add and the unused op answer from idle, done_o in the cycle after the
// request is taken. Remove and tick walk the live rows through one RAM
// read port and one evaluation unit, a read and an evaluate state a row
// visited, then a read and a write state a row moved down after a drop.
// busy_o stays high for the whole walk, so one request is in flight.
// Reset clears the live count and sets the next id to 1; the table RAM is
// not cleared, as only live rows are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timeout_table_scheduler #(
  parameter int unsigned SLOTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] duration_ms_i,
  input  wire logic [31:0] payload_tag_i,
  input  wire logic [31:0] entry_id_i,
  input  wire logic [31:0] now_ms_i,
  output logic             done_o,
  output logic             ok_o,
  output logic [31:0]      result_id_o,
  output logic [31:0]      fired_tag_o
);

  import tts_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_SH_RD, S_SH_WR} state_e;

  state_e      state_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;
  logic [31:0] nid_q;
  logic [1:0]  op_q;
  logic [31:0] eid_q;
  logic [31:0] now_q;

  logic          we;
  logic [AW-1:0] waddr;
  tts_row_t      wrow;
  logic [AW-1:0] raddr;
  logic [ROW_W-1:0] rdata;
  tts_row_t      rrow;
  tts_eval_t     ev;

  logic          accept;
  logic          last_row;
  logic          last_move;
  logic [31:0]   nid_inc;

  assign accept    = start_i && !busy_o;
  assign rrow      = tts_row_t'(rdata);
  assign last_row  = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign last_move = (CW'(idx_q) + CW'(2)) == cnt_q;
  assign nid_inc   = nid_q + 32'd1;

  tts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ROW_W'(wrow)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tts_eval u_eval (
    .row_i (rrow),
    .now_i (now_q),
    .eid_i (eid_q),
    .res_o (ev)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wrow  = rrow;
    raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        waddr        = cnt_q[AW-1:0];
        wrow.id      = nid_q;
        wrow.dur     = duration_ms_i;
        wrow.tag     = payload_tag_i;
        wrow.started = 1'b0;
        we = accept && (op_i == OP_ADD) && (cnt_q != CW'(SLOTS));
      end
      S_EV: begin
        wrow.started = 1'b1;
        wrow.start   = now_q;
        wrow.expiry  = ev.expiry;
        we = (op_q == OP_TICK) && !rrow.started;
      end
      S_SH_RD: begin
        raddr = idx_q + AW'(1);
      end
      S_SH_WR: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign busy_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      nid_q       <= ID_FIRST;
      idx_q       <= '0;
      done_o      <= 1'b0;
      ok_o        <= 1'b0;
      result_id_o <= '0;
      fired_tag_o <= '0;
      op_q        <= OP_ADD;
      eid_q       <= '0;
      now_q       <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q        <= op_i;
            eid_q       <= entry_id_i;
            now_q       <= now_ms_i;
            idx_q       <= '0;
            ok_o        <= 1'b0;
            result_id_o <= '0;
            fired_tag_o <= '0;
            if (op_i == OP_ADD) begin
              done_o <= 1'b1;
              if (cnt_q != CW'(SLOTS)) begin
                ok_o        <= 1'b1;
                result_id_o <= nid_q;
                cnt_q       <= cnt_q + CW'(1);
                nid_q       <= (nid_inc == 32'd0) ? ID_FIRST : nid_inc;
              end
            end else if ((op_i == OP_REMOVE || op_i == OP_TICK) && cnt_q != '0) begin
              state_q <= S_RD;
            end else begin
              done_o <= 1'b1;
            end
          end
        end
        S_RD: begin
          state_q <= S_EV;
        end
        S_EV: begin
          if ((op_q == OP_REMOVE && ev.id_match) ||
              (op_q == OP_TICK && rrow.started && ev.expired)) begin
            ok_o <= 1'b1;
            if (op_q == OP_TICK) begin
              result_id_o <= rrow.id;
              fired_tag_o <= rrow.tag;
            end
            if (last_row) begin
              cnt_q   <= cnt_q - CW'(1);
              done_o  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_SH_RD;
            end
          end else if (last_row) begin
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_RD;
          end
        end
        S_SH_RD: begin
          state_q <= S_SH_WR;
        end
        S_SH_WR: begin
          if (last_move) begin
            cnt_q   <= cnt_q - CW'(1);
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SH_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("live count above table size");

  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_EV) |-> CW'(idx_q) < cnt_q)
    else $error("walk index beyond live rows");

  a_add_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_ADD && cnt_q != CW'(SLOTS)) |=> (done_o && ok_o))
    else $error("add to non-full table did not complete");

  a_empty_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i != OP_ADD && cnt_q == '0) |=> (done_o && !ok_o))
    else $error("request on empty table did not complete at once");

  a_nonzero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o && op_q != OP_REMOVE) |-> result_id_o != 32'd0)
    else $error("reported id is zero");
`endif

endmodule

`default_nettype wire
